// ===== design/ttq_pkg.sv =====
// Shared constants and codes for the timer task queue.
package ttq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BUSY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NO_DISP = 2'd3;

  typedef logic [TIME_W-1:0] time_ms_t;
  typedef logic [ID_W-1:0]   task_id_t;

endpackage

// ===== design/timer_task_queue_core.sv =====
// Sorted timer queue: deadline-ordered task slots walked by one shared compare/add unit.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: task_id, delay_ms, now_ms
//  out_    | out | out_tvalid/tready  | tdata: run_task, run_id, wait_ms, status
//
// Each request is accepted, walks the slots that it needs, then presents its result;
// add and reschedule move one slot a cycle through the single comparator, remove
// shifts one slot a cycle.
// Reset (rst_n low, synchronous) empties the queue and drops any pending dispatch.
// in_tready is low from accept until the result has been taken; a stalled out_tready
// holds the result and the block.
module timer_task_queue_core
  import ttq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // task_id[7:0], delay_ms[39:8], now_ms[71:40]
  input  logic [OP_W-1:0]       in_tuser,   // operation[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // run_task[0], run_id[8:1], wait_ms[40:9],
                                            // status[42:41]
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TICK = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_DEL  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  time_ms_t dl_r [QUEUE_DEPTH];
  task_id_t id_r [QUEUE_DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pending_r, pending_nxt;
  time_ms_t          last_time_r, last_time_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  time_ms_t          key_r, key_nxt;
  task_id_t          tid_r, tid_nxt;
  logic              res_run_r, res_run_nxt;
  task_id_t          res_id_r, res_id_nxt;
  time_ms_t          res_wait_r, res_wait_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;

  logic [OP_W-1:0]  in_op;
  task_id_t         in_id;
  time_ms_t         in_delay;
  time_ms_t         in_now;
  logic             in_acc;

  logic [IDX_W-1:0] rd_idx;
  time_ms_t         rd_dl;
  time_ms_t         cmp_lhs, cmp_rhs;
  logic             cmp_gt;
  time_ms_t         add_a, add_b, add_sum;
  logic             add_cin;
  logic [CNT_W-1:0] idx_next_cnt;
  logic             floor_hit;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  time_ms_t         wr_dl;
  task_id_t         wr_id;

  assign in_op    = in_tuser;
  assign in_id    = in_tdata[7:0];
  assign in_delay = in_tdata[39:8];
  assign in_now   = in_tdata[71:40];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'd0, res_status_r, res_wait_r, res_id_r, res_run_r};

  assign idx_next_cnt = CNT_W'(idx_r) + CNT_W'(1);
  assign floor_hit    = pending_r ? (idx_r <= IDX_W'(1)) : (idx_r == '0);

  always_comb begin
    case (state_r)
      ST_INS:  rd_idx = idx_r - IDX_W'(1);
      ST_RES:  rd_idx = idx_r + IDX_W'(1);
      ST_DEL:  rd_idx = idx_r + IDX_W'(1);
      default: rd_idx = '0;
    endcase
  end

  assign rd_dl = dl_r[rd_idx];

  always_comb begin
    case (state_r)
      ST_RES: begin
        cmp_lhs = key_r;
        cmp_rhs = rd_dl;
      end
      ST_TICK: begin
        cmp_lhs = rd_dl;
        cmp_rhs = last_time_r;
      end
      default: begin
        cmp_lhs = rd_dl;
        cmp_rhs = key_r;
      end
    endcase
  end

  assign cmp_gt = cmp_lhs > cmp_rhs;

  always_comb begin
    if (state_r == ST_TICK) begin
      add_a   = rd_dl;
      add_b   = ~last_time_r;
      add_cin = 1'b1;
    end else begin
      add_a   = last_time_r;
      add_b   = in_delay;
      add_cin = 1'b0;
    end
  end

  assign add_sum = add_a + add_b + TIME_W'(add_cin);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pending_nxt    = pending_r;
    last_time_nxt  = last_time_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    tid_nxt        = tid_r;
    res_run_nxt    = res_run_r;
    res_id_nxt     = res_id_r;
    res_wait_nxt   = res_wait_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    wr_dl          = key_r;
    wr_id          = tid_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_run_nxt    = 1'b0;
          res_id_nxt     = '0;
          res_wait_nxt   = '0;
          res_status_nxt = STAT_OK;
          key_nxt        = add_sum;
          tid_nxt        = in_id;
          idx_nxt        = '0;
          state_nxt      = ST_OUT;
          case (in_op)
            OP_ADD: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                idx_nxt   = count_r[IDX_W-1:0];
                state_nxt = ST_INS;
              end
            end
            OP_TICK: begin
              last_time_nxt = in_now;
              if (pending_r) begin
                res_status_nxt = STAT_BUSY;
              end else if (count_r != '0) begin
                state_nxt = ST_TICK;
              end
            end
            OP_COMPLETE: begin
              if (!pending_r) begin
                res_status_nxt = STAT_NO_DISP;
              end else begin
                pending_nxt = 1'b0;
                tid_nxt     = id_r[0];
                state_nxt   = (in_delay == '0) ? ST_DEL : ST_RES;
              end
            end
            default: begin
              count_nxt   = '0;
              pending_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (cmp_gt) begin
          res_wait_nxt = add_sum;
        end else begin
          res_run_nxt = 1'b1;
          res_id_nxt  = id_r[0];
          pending_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_INS: begin
        wr_en = 1'b1;
        if (!floor_hit && cmp_gt) begin
          wr_dl   = rd_dl;
          wr_id   = id_r[rd_idx];
          idx_nxt = rd_idx;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_OUT;
        end
      end
      ST_RES: begin
        wr_en = 1'b1;
        if ((idx_next_cnt < count_r) && cmp_gt) begin
          wr_dl   = rd_dl;
          wr_id   = id_r[rd_idx];
          idx_nxt = rd_idx;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DEL: begin
        if (idx_next_cnt < count_r) begin
          wr_en   = 1'b1;
          wr_dl   = rd_dl;
          wr_id   = id_r[rd_idx];
          idx_nxt = rd_idx;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pending_r   <= 1'b0;
      last_time_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    tid_r        <= tid_nxt;
    res_run_r    <= res_run_nxt;
    res_id_r     <= res_id_nxt;
    res_wait_r   <= res_wait_nxt;
    res_status_r <= res_status_nxt;
    if (wr_en) begin
      dl_r[wr_idx] <= wr_dl;
      id_r[wr_idx] <= wr_id;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pending_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (count_r != '0))
    else $error("dispatch pending on an empty queue");

  a_run_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_run_r) |-> pending_r)
    else $error("dispatch reported without pending flag");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_add_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS && state_nxt == ST_OUT) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow queue by one");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the sorted timer queue: a directed table, then weighted random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttq_pkg::*;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_AT        = 900;
  localparam int STEADY_FROM     = 1200;
  localparam int STEADY_TO       = 1500;
  localparam int IDLE_PCT        = 11;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [OP_W-1:0] op;
    task_id_t        id;
    time_ms_t        delay_ms;
    time_ms_t        now_ms;
  } req_t;

  typedef struct packed {
    logic              run;
    task_id_t          id;
    time_ms_t          wait_ms;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  time_ms_t q_deadline [QUEUE_DEPTH];
  task_id_t q_task     [QUEUE_DEPTH];
  bit       q_valid    [QUEUE_DEPTH];
  time_ms_t q_last_time;
  bit       q_pending;

  res_t awaited_results[$];
  row_t rows[$];

  int  sent_count;
  int  errors;
  int  n_results;
  int  n_dispatch;
  int  n_full;
  int  n_busy;
  int  n_directed;
  bit  steady;
  bit  hold_done;
  res_t got;
  res_t want;

  timer_task_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t apply_request(req_t rq);
    res_t     rs;
    int       n;
    int       i;
    time_ms_t dl;
    task_id_t head_id;
    rs = '0;
    case (rq.op)
      OP_ADD: begin
        n = 0;
        while (n < QUEUE_DEPTH && q_valid[n]) n++;
        if (n >= QUEUE_DEPTH) begin
          rs.status = STAT_FULL;
        end else begin
          dl = q_last_time + rq.delay_ms;
          i = n;
          while (i > (q_pending ? 1 : 0) && q_deadline[i-1] > dl) begin
            q_deadline[i] = q_deadline[i-1];
            q_task[i]     = q_task[i-1];
            q_valid[i]    = q_valid[i-1];
            i--;
          end
          q_deadline[i] = dl;
          q_task[i]     = rq.id;
          q_valid[i]    = 1'b1;
        end
      end
      OP_TICK: begin
        q_last_time = rq.now_ms;
        if (q_pending) begin
          rs.status = STAT_BUSY;
        end else if (q_valid[0]) begin
          if (q_deadline[0] <= rq.now_ms) begin
            rs.run    = 1'b1;
            rs.id     = q_task[0];
            q_pending = 1'b1;
          end else begin
            rs.wait_ms = q_deadline[0] - rq.now_ms;
          end
        end
      end
      OP_COMPLETE: begin
        if (!q_pending) begin
          rs.status = STAT_NO_DISP;
        end else begin
          q_pending = 1'b0;
          if (rq.delay_ms == '0) begin
            for (i = 0; i + 1 < QUEUE_DEPTH; i++) begin
              q_deadline[i] = q_deadline[i+1];
              q_task[i]     = q_task[i+1];
              q_valid[i]    = q_valid[i+1];
            end
            q_deadline[QUEUE_DEPTH-1] = '0;
            q_task[QUEUE_DEPTH-1]     = '0;
            q_valid[QUEUE_DEPTH-1]    = 1'b0;
          end else begin
            dl      = q_last_time + rq.delay_ms;
            head_id = q_task[0];
            i = 0;
            while (i + 1 < QUEUE_DEPTH && q_valid[i+1] && q_deadline[i+1] < dl) begin
              q_deadline[i] = q_deadline[i+1];
              q_task[i]     = q_task[i+1];
              q_valid[i]    = q_valid[i+1];
              i++;
            end
            q_deadline[i] = dl;
            q_task[i]     = head_id;
            q_valid[i]    = 1'b1;
          end
        end
      end
      default: begin
        for (i = 0; i < QUEUE_DEPTH; i++) begin
          q_deadline[i] = '0;
          q_task[i]     = '0;
          q_valid[i]    = 1'b0;
        end
        q_pending = 1'b0;
      end
    endcase
    return rs;
  endfunction

  function automatic req_t pick_request();
    req_t rq;
    int   k;
    rq.op       = OP_W'($urandom_range(0, 3));
    rq.id       = task_id_t'($urandom);
    rq.delay_ms = $urandom;
    rq.now_ms   = $urandom;
    if ($urandom_range(0, 99) < 90) begin
      if (q_pending && $urandom_range(0, 99) < 70) begin
        rq.op = OP_COMPLETE;
        k = $urandom_range(0, 9);
        if (k < 5) rq.delay_ms = '0;
        else if (k < 9) rq.delay_ms = $urandom_range(1, 40);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 45) begin
          rq.op = OP_ADD;
          if (k >= 10) rq.delay_ms = $urandom_range(1, 60);
          else if (k >= 5) rq.delay_ms = '0;
        end else if (k < 95) begin
          rq.op = OP_TICK;
          case ($urandom_range(0, 29))
            0:       rq.now_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            1:       ;
            2, 3:    rq.now_ms = q_last_time;
            default: rq.now_ms = q_last_time + $urandom_range(1, 25);
          endcase
        end else if (k < 97) begin
          rq.op = OP_COMPLETE;
        end else begin
          rq.op = OP_CLEAR;
        end
      end
    end
    return rq;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, task_id_t id, time_ms_t delay_ms,
                         time_ms_t now_ms, bit typed, res_t want_rs);
    row_t r;
    r.rq    = '{op: op, id: id, delay_ms: delay_ms, now_ms: now_ms};
    r.typed = typed;
    r.want  = want_rs;
    rows.push_back(r);
  endtask

  task automatic offer(req_t rq, bit typed, res_t want_rs);
    res_t rs;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.op;
    in_tdata  <= {rq.now_ms, rq.delay_ms, rq.id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rs = apply_request(rq);
    awaited_results.push_back(typed ? want_rs : rs);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= 600) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.run     = out_tdata[0];
      got.id      = out_tdata[8:1];
      got.wait_ms = out_tdata[40:9];
      got.status  = out_tdata[42:41];
      n_results++;
      if (got.run === 1'b1) n_dispatch++;
      if (got.status === STAT_FULL) n_full++;
      if (got.status === STAT_BUSY) n_busy++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with nothing awaited: run=%b id=%h wait=%h status=%0d",
                   $time, got.run, got.id, got.wait_ms, got.status);
      end else begin
        want = awaited_results.pop_front();
        if (got.run !== want.run || got.id !== want.id || got.wait_ms !== want.wait_ms ||
            got.status !== want.status) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: exp run=%b id=%h wait=%h st=%0d, got run=%b id=%h wait=%h st=%0d",
                     $time, want.run, want.id, want.wait_ms, want.status,
                     got.run, got.id, got.wait_ms, got.status);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still awaited", awaited_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_t rq;
    int   n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    steady     = 1'b0;
    sent_count = 0;
    errors     = 0;
    n_results  = 0;
    n_dispatch = 0;
    n_full     = 0;
    n_busy     = 0;
    for (n = 0; n < QUEUE_DEPTH; n++) begin
      q_deadline[n] = '0;
      q_task[n]     = '0;
      q_valid[n]    = 1'b0;
    end
    q_last_time = '0;
    q_pending   = 1'b0;

    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_COMPLETE, 8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_NO_DISP});
    add_row(OP_ADD,      8'hFF, 32'hFFFF_FFFF, 32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         1,
            '{1'b0, 8'h00, 32'hFFFF_FFFF, STAT_OK});
    add_row(OP_ADD,      8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         1, '{1'b1, 8'h00, 32'h0, STAT_OK});
    add_row(OP_TICK,     8'h00, 32'h0,         32'h5,         1, '{1'b0, 8'h00, 32'h0, STAT_BUSY});
    add_row(OP_ADD,      8'h11, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_COMPLETE, 8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_TICK,     8'h00, 32'h0,         32'hFFFF_FFFF, 1, '{1'b1, 8'h11, 32'h0, STAT_OK});
    add_row(OP_COMPLETE, 8'h00, 32'h1,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h22, 32'h1,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h33, 32'h3,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h44, 32'h3,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h55, 32'h2,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h66, 32'h2,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h77, 32'h3,         32'h0,         0, '0);
    add_row(OP_ADD,      8'h88, 32'h1,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_FULL});
    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         0, '0);
    add_row(OP_COMPLETE, 8'h00, 32'h2,         32'h0,         0, '0);
    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         0, '0);
    add_row(OP_COMPLETE, 8'h00, 32'h0,         32'h0,         0, '0);
    add_row(OP_TICK,     8'h00, 32'h0,         32'h1,         0, '0);
    add_row(OP_ADD,      8'h99, 32'hFFFF_FFFF, 32'h0,         0, '0);
    add_row(OP_CLEAR,    8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    add_row(OP_TICK,     8'h00, 32'h0,         32'h0,         1, '{1'b0, 8'h00, 32'h0, STAT_OK});
    n_directed = rows.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) offer(rows[i].rq, rows[i].typed, rows[i].want);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == DRAIN_AT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0) @(negedge clk);
      end
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      rq = pick_request();
      offer(rq, 1'b0, '0);
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 4) @(negedge clk);

    $display("Ran %0d requests (%0d directed) for %0d results: %0d dispatches,",
             sent_count, n_directed, n_results, n_dispatch);
    $display("%0d dropped adds on a full queue, %0d busy ticks, %0d mismatches",
             n_full, n_busy, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ttq_pkg.sv
design/timer_task_queue_core.sv
tb/tb.sv
